>>> hw/rtl/assert_macros.svh
// Concurrent assertion helpers; expect clk and arst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every edge outside reset
`define CFCB_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// cons must hold in the same cycle as ante
`define CFCB_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// cons must hold in the cycle after ante
`define CFCB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/cfcb_pkg.sv
`default_nettype none

package cfcb_pkg;

	localparam int MAX_FRAME_LEN = 64;
	localparam int TEXT_LIMIT    = MAX_FRAME_LEN - 3;
	localparam int CNT_W         = $clog2(TEXT_LIMIT + 1);

	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_TOP  = 16'h8000;
	localparam logic [15:0] CRC_INIT = 16'h0000;
	localparam logic [7:0]  CR_BYTE  = 8'h0D;

	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic [1:0] {
		PH_TEXT,
		PH_CRC_HI,
		PH_CRC_LO,
		PH_CR
	} phase_t;

	// request held in the input stage
	typedef struct packed {
		logic       vld;
		logic [7:0] cmd_byte;
		logic       last_byte;
	} item_t;

	// CRC-16/XMODEM over one byte, MSB first
	function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if ((c & CRC_TOP) != 16'h0000) begin
				c = (c << 1) ^ CRC_POLY;
			end else begin
				c = c << 1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/cfcb_if.sv
`default_nettype none

interface cfcb_cmd_if;
	logic       valid;
	logic       ready;
	logic [7:0] cmd_byte;
	logic       last_byte;

	modport source (output valid, output cmd_byte, output last_byte, input ready);
	modport sink   (input valid, input cmd_byte, input last_byte, output ready);
endinterface

interface cfcb_frame_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       frame_end;
	logic       overflow;

	modport source (output valid, output out_byte, output frame_end, output overflow,
		input ready);
	modport sink   (input valid, input out_byte, input frame_end, input overflow,
		output ready);
endinterface

`default_nettype wire

>>> hw/rtl/cfcb_in_reg.sv
`default_nettype none

module cfcb_in_reg (
	input  wire logic           clk,
	input  wire logic           arst_n,
	cfcb_cmd_if.sink            cmd,
	input  wire logic           take,
	output cfcb_pkg::item_t     item
);
	import cfcb_pkg::*;

	logic       vld_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       load;

	// refill in the same cycle the held request retires
	assign cmd.ready = !vld_s1 || take;
	assign load      = cmd.valid && cmd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (load) begin
			vld_s1 <= 1'b1;
		end else if (take) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_s1 <= cmd.cmd_byte;
			last_s1 <= cmd.last_byte;
		end
	end

	assign item = '{vld: vld_s1, cmd_byte: byte_s1, last_byte: last_s1};

endmodule

`default_nettype wire

>>> hw/rtl/cfcb_framer.sv
`default_nettype none
`include "assert_macros.svh"

module cfcb_framer (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire cfcb_pkg::item_t item,
	output logic                take,
	cfcb_frame_if.source        frame
);
	import cfcb_pkg::*;

	phase_t      phase_q, phase_d;
	logic [15:0] crc_q, crc_d;
	cnt_t        cnt_q, cnt_d;
	logic        drop_q, drop_d;

	logic        out_vld_q;
	logic [7:0]  out_byte_q;
	logic        frame_end_q;
	logic        ovf_q;

	logic        out_free;
	logic        go;
	logic        room;
	logic        emit;
	logic [7:0]  byte_d;
	logic        end_d;
	logic        ovf_d;

	assign out_free = !out_vld_q || frame.ready;
	assign go       = item.vld && out_free;
	assign room     = cnt_q < CNT_W'(TEXT_LIMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TEXT;
			crc_q   <= CRC_INIT;
			cnt_q   <= '0;
			drop_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			crc_q   <= crc_d;
			cnt_q   <= cnt_d;
			drop_q  <= drop_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		crc_d   = crc_q;
		cnt_d   = cnt_q;
		drop_d  = drop_q;
		take    = 1'b0;
		emit    = 1'b0;
		byte_d  = item.cmd_byte;
		end_d   = 1'b0;
		ovf_d   = 1'b0;
		if (go) begin
			case (phase_q)
				PH_TEXT: begin
					if (room) begin
						emit  = 1'b1;
						crc_d = crc_fold(crc_q, item.cmd_byte);
						cnt_d = cnt_q + 1'b1;
					end else begin
						// frame full: drop byte, keep CRC
						drop_d = 1'b1;
					end
					if (item.last_byte) begin
						phase_d = PH_CRC_HI;
					end else begin
						take = 1'b1;
					end
				end
				PH_CRC_HI: begin
					emit    = 1'b1;
					byte_d  = crc_q[15:8];
					ovf_d   = drop_q;
					phase_d = PH_CRC_LO;
				end
				PH_CRC_LO: begin
					emit    = 1'b1;
					byte_d  = crc_q[7:0];
					ovf_d   = drop_q;
					phase_d = PH_CR;
				end
				PH_CR: begin
					emit    = 1'b1;
					byte_d  = CR_BYTE;
					end_d   = 1'b1;
					ovf_d   = drop_q;
					take    = 1'b1;
					crc_d   = CRC_INIT;
					cnt_d   = '0;
					drop_d  = 1'b0;
					phase_d = PH_TEXT;
				end
				default: begin
					phase_d = PH_TEXT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_free) begin
			out_vld_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && emit) begin
			out_byte_q  <= byte_d;
			frame_end_q <= end_d;
			ovf_q       <= ovf_d;
		end
	end

	assign frame.valid     = out_vld_q;
	assign frame.out_byte  = out_byte_q;
	assign frame.frame_end = frame_end_q;
	assign frame.overflow  = ovf_q;

	`CFCB_ASSERT_ALWAYS(a_cnt_limit, cnt_q <= CNT_W'(TEXT_LIMIT),
		"text count past frame limit")
	`CFCB_ASSERT_IMPLY(a_trailer_holds_req, phase_q != PH_TEXT, item.vld,
		"trailer in progress without a held request")
	`CFCB_ASSERT_IMPLY(a_end_is_cr, out_vld_q && frame_end_q, out_byte_q == CR_BYTE,
		"frame end flagged on a byte other than carriage return")
	`CFCB_ASSERT_NEXT(a_clear_after_cr, go && phase_q == PH_CR,
		cnt_q == '0 && !drop_q && crc_q == CRC_INIT && phase_q == PH_TEXT,
		"frame state not cleared after carriage return")

endmodule

`default_nettype wire

>>> hw/rtl/command_frame_crc16_builder_unit.sv
//  channel | modport | payload                          | handshake
//  cmd     | sink    | cmd_byte[7:0], last_byte         | valid/ready
//  frame   | source  | out_byte[7:0], frame_end, overflow | valid/ready
//
//  One text byte per cycle unless frame.ready stalls the output; a byte marked
//  last holds the input stage through text byte or empty slot, CRC high, CRC
//  low, carriage return. Requests pass input stage, then output register.
//  Stalls on frame.ready propagate to cmd.ready combinationally.
//  Reset clears the CRC, text count, drop flag and all valid bits.
`default_nettype none

module command_frame_crc16_builder_unit (
	input  wire logic    clk,
	input  wire logic    arst_n,
	cfcb_cmd_if.sink     cmd,
	cfcb_frame_if.source frame
);
	import cfcb_pkg::*;

	item_t item;
	logic  take;

	cfcb_in_reg u_in_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.take   (take),
		.item   (item)
	);

	cfcb_framer u_framer (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.take   (take),
		.frame  (frame)
	);

endmodule

`default_nettype wire
